// ===== sv/rpe_pkg.sv =====
// Shared constants and types of the rational polynomial evaluator.
package rpe_pkg;

  // Fixed-point format: signed words with FRAC_BITS fraction bits
  localparam int WORD      = 32;
  localparam int FRAC_BITS = 16;
  localparam int MAX_TERMS = 3;
  localparam int TERM_W    = 2;
  localparam int IDX_W     = 3;

  // Divider dividend is the numerator scaled up by the fraction bits
  localparam int DVD_W = WORD + FRAC_BITS;
  localparam int CNT_W = $clog2(DVD_W + 1);

  localparam logic [WORD-1:0] ONE_FIX = WORD'(1) << FRAC_BITS;
  localparam logic [WORD-1:0] S_MAX   = {1'b0, {(WORD-1){1'b1}}};
  localparam logic [WORD-1:0] S_MIN   = {1'b1, {(WORD-1){1'b0}}};

  // Term counts at which the linear and quadratic terms are in use
  localparam logic [TERM_W-1:0] TERMS_LIN   = TERM_W'(2);
  localparam logic [TERM_W-1:0] TERMS_QUAD  = TERM_W'(3);
  localparam logic [TERM_W-1:0] TERMS_LIMIT = TERM_W'(MAX_TERMS);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_NUM_TERMS = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_DEN_TERMS = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_NUM_COEF0 = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_NUM_COEF1 = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_NUM_COEF2 = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_DEN_COEF0 = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_DEN_COEF1 = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_DEN_COEF2 = IDX_W'(7);

  // Register file contents
  typedef struct packed {
    logic [TERM_W-1:0] num_terms;
    logic [TERM_W-1:0] den_terms;
    logic [WORD-1:0]   num_coef0;
    logic [WORD-1:0]   num_coef1;
    logic [WORD-1:0]   num_coef2;
    logic [WORD-1:0]   den_coef0;
    logic [WORD-1:0]   den_coef1;
    logic [WORD-1:0]   den_coef2;
  } cfg_t;

  // Divider request and result
  typedef struct packed {
    logic            start;
    logic [WORD-1:0] num;
    logic [WORD-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [WORD-1:0] quo;
    logic            ovf;
  } div_res_t;

endpackage

// ===== sv/rpe_cfg_regs.sv =====
// Configuration register file of the rational polynomial evaluator.
module rpe_cfg_regs
  import rpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [WORD-1:0]  cfg_wdata,
  output cfg_t             cfg
);

  cfg_t regs_r;

  // Decode the index; term counts keep their low bits only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.num_terms <= TERM_W'(1);
      regs_r.den_terms <= TERM_W'(0);
      regs_r.num_coef0 <= '0;
      regs_r.num_coef1 <= ONE_FIX;
      regs_r.num_coef2 <= '0;
      regs_r.den_coef0 <= ONE_FIX;
      regs_r.den_coef1 <= '0;
      regs_r.den_coef2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_TERMS: regs_r.num_terms <= cfg_wdata[TERM_W-1:0];
        REG_DEN_TERMS: regs_r.den_terms <= cfg_wdata[TERM_W-1:0];
        REG_NUM_COEF0: regs_r.num_coef0 <= cfg_wdata;
        REG_NUM_COEF1: regs_r.num_coef1 <= cfg_wdata;
        REG_NUM_COEF2: regs_r.num_coef2 <= cfg_wdata;
        REG_DEN_COEF0: regs_r.den_coef0 <= cfg_wdata;
        REG_DEN_COEF1: regs_r.den_coef1 <= cfg_wdata;
        REG_DEN_COEF2: regs_r.den_coef2 <= cfg_wdata;
        default:       regs_r <= regs_r;
      endcase
    end
  end

  assign cfg = regs_r;

endmodule

// ===== sv/rpe_mul.sv =====
// Shared fixed-point multiplier: registered product, floor shift, saturation.
module rpe_mul
  import rpe_pkg::*;
(
  input  logic            clk,
  input  logic [WORD-1:0] op_a,
  input  logic [WORD-1:0] op_b,
  output logic [WORD-1:0] res,
  output logic            ovf
);

  localparam int PROD_W = 2 * WORD;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] shifted;
  logic [PROD_W-WORD:0]     hi;

  // Product of the operands issued in the previous cycle
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'($signed(op_a) * $signed(op_b));
  end

  // Arithmetic shift rounds toward minus infinity
  assign shifted = prod_r >>> FRAC_BITS;
  assign hi      = shifted[PROD_W-1:WORD-1];

  // Fits when all bits above the sign position agree
  always_comb begin
    ovf = !((&hi) || !(|hi));
    if (!ovf) begin
      res = shifted[WORD-1:0];
    end else if (shifted[PROD_W-1]) begin
      res = S_MIN;
    end else begin
      res = S_MAX;
    end
  end

endmodule

// ===== sv/rpe_div.sv =====
// Iterative restoring divider: (num << FRAC_BITS) / den, truncated, saturated.
module rpe_div
  import rpe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_res_t res
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIN
  } dstate_t;

  localparam logic [DVD_W-1:0] NEG_LIMIT = DVD_W'(S_MIN);
  localparam logic [DVD_W-1:0] POS_LIMIT = DVD_W'(S_MAX);

  dstate_t          state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [WORD-1:0]  rem_r;
  logic [WORD-1:0]  dvs_r;
  logic             neg_r;
  logic             done_r;
  logic [WORD-1:0]  quo_r;
  logic             ovf_r;

  logic [WORD-1:0]  num_mag;
  logic [WORD-1:0]  den_mag;
  logic [WORD:0]    shift_rem;
  logic [WORD+1:0]  diff;
  logic             qbit;
  logic [WORD-1:0]  rem_nxt;

  // Operand magnitudes; the most negative value maps to its unsigned magnitude
  assign num_mag = req.num[WORD-1] ? (~req.num + WORD'(1)) : req.num;
  assign den_mag = req.den[WORD-1] ? (~req.den + WORD'(1)) : req.den;

  // One quotient bit per cycle
  assign shift_rem = {rem_r, dvd_r[DVD_W-1]};
  assign diff      = {1'b0, shift_rem} - {2'b00, dvs_r};
  assign qbit      = !diff[WORD+1];
  assign rem_nxt   = qbit ? diff[WORD-1:0] : shift_rem[WORD-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (req.start) begin
            dvd_r   <= {num_mag, {FRAC_BITS{1'b0}}};
            dvs_r   <= den_mag;
            rem_r   <= '0;
            neg_r   <= req.num[WORD-1] ^ req.den[WORD-1];
            cnt_r   <= CNT_W'(DVD_W - 1);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          dvd_r <= {dvd_r[DVD_W-2:0], qbit};
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= D_FIN;
          end
        end
        D_FIN: begin
          // Apply the sign and saturate the magnitude
          if (neg_r) begin
            ovf_r <= dvd_r > NEG_LIMIT;
            quo_r <= (dvd_r > NEG_LIMIT) ? S_MIN : (~dvd_r[WORD-1:0] + WORD'(1));
          end else begin
            ovf_r <= dvd_r > POS_LIMIT;
            quo_r <= (dvd_r > POS_LIMIT) ? S_MAX : dvd_r[WORD-1:0];
          end
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.ovf  = ovf_r;

endmodule

// ===== sv/rational_polynomial_evaluator_core.sv =====
// Top level of the rational polynomial evaluator: sequencer over shared units.
//
// Each request on the in_ stream carries one point x (signed Q16.16). The block
// evaluates N(x) and D(x) from the configured coefficients (ascending powers,
// a side with zero terms is 1.0) and returns N/D in Q16.16 on the out_ stream,
// with overflow and divide_by_zero flags in out_tuser.
// One request is in work at a time; in_tready is high only while idle.
// From accept, each side loads its constant term and then, where in use, adds
// a linear and a quadratic term; then the divider runs, one quotient bit per
// cycle over 48 bits plus sign fix-up and hand-back, unless D(x) is zero;
// last the result is loaded into the output register.
// Every product goes through the one shared 32x32 multiplier.
// A finished result waits in the output register while out_tready is low;
// the next request may be accepted meanwhile, and its result waits in the
// sequencer until the output register is free.
// Configuration writes take effect at once; the user must make them only while idle, as the block does not enforce it.
// Reset (rst_n low, synchronous) restores the register defaults (N = 0,
// D = 1) and empties the block.
module rational_polynomial_evaluator_core
  import rpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // in_tdata: [31:0] point
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [WORD-1:0]  in_tdata,
  // out_tdata: [31:0] ratio
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [WORD-1:0]  out_tdata,
  // out_tuser: [0] overflow, [1] divide_by_zero
  output logic [1:0]       out_tuser,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [WORD-1:0]  cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SIDE,
    S_LIN,
    S_LIN_ADD,
    S_SQ,
    S_QUAD,
    S_QUAD_W,
    S_QUAD_ADD,
    S_END,
    S_DIV,
    S_DONE
  } state_t;

  cfg_t     cfg;
  div_req_t div_req;
  div_res_t div_res;

  state_t          state_r;
  logic            side_r;
  logic [WORD-1:0] x_r;
  logic [WORD-1:0] acc_r;
  logic [WORD-1:0] term_r;
  logic [WORD-1:0] num_r;
  logic            ovf_r;
  logic            dz_r;
  logic [WORD-1:0] q_r;
  logic            out_valid_r;
  logic [WORD-1:0] out_data_r;
  logic [1:0]      out_user_r;

  logic [TERM_W-1:0] terms_sel;
  logic [TERM_W-1:0] terms_eff;
  logic [WORD-1:0]   c0;
  logic [WORD-1:0]   c1;
  logic [WORD-1:0]   c2;
  logic              use_lin;
  logic              use_quad;
  logic [WORD-1:0]   mul_a;
  logic [WORD-1:0]   mul_b;
  logic [WORD-1:0]   mul_res;
  logic              mul_ovf;
  logic [WORD:0]     sum;
  logic              sum_ovf;
  logic [WORD-1:0]   acc_nxt;
  logic              out_free;

  rpe_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rpe_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .res  (mul_res),
    .ovf  (mul_ovf)
  );

  rpe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  // Coefficients of the side in work
  assign terms_sel = side_r ? cfg.den_terms : cfg.num_terms;
  assign terms_eff = (terms_sel > TERMS_LIMIT) ? TERMS_LIMIT : terms_sel;
  assign c0        = side_r ? cfg.den_coef0 : cfg.num_coef0;
  assign c1        = side_r ? cfg.den_coef1 : cfg.num_coef1;
  assign c2        = side_r ? cfg.den_coef2 : cfg.num_coef2;
  assign use_lin   = (terms_eff >= TERMS_LIN) && (c1 != '0);
  assign use_quad  = (terms_eff >= TERMS_QUAD) && (c2 != '0);

  // Multiplier operands: x*c1, x*x, then x^2*c2
  always_comb begin
    if (state_r == S_QUAD) begin
      mul_a = term_r;
      mul_b = c2;
    end else if ((state_r == S_SIDE) && use_lin) begin
      mul_a = x_r;
      mul_b = c1;
    end else begin
      mul_a = x_r;
      mul_b = x_r;
    end
  end

  // Saturating accumulate
  assign sum     = {acc_r[WORD-1], acc_r} + {term_r[WORD-1], term_r};
  assign sum_ovf = sum[WORD] != sum[WORD-1];
  assign acc_nxt = !sum_ovf ? sum[WORD-1:0] : (sum[WORD] ? S_MIN : S_MAX);

  // Divider request once the denominator is known and nonzero
  assign div_req.start = (state_r == S_END) && side_r && (acc_r != '0);
  assign div_req.num   = num_r;
  assign div_req.den   = acc_r;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Load a finished result, else drop the one just taken
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            x_r     <= in_tdata;
            side_r  <= 1'b0;
            ovf_r   <= 1'b0;
            state_r <= S_SIDE;
          end
        end
        S_SIDE: begin
          acc_r <= (terms_eff == '0) ? ONE_FIX : c0;
          if (use_lin) begin
            state_r <= S_LIN;
          end else if (use_quad) begin
            state_r <= S_SQ;
          end else begin
            state_r <= S_END;
          end
        end
        S_LIN: begin
          term_r  <= mul_res;
          ovf_r   <= ovf_r | mul_ovf;
          state_r <= S_LIN_ADD;
        end
        S_LIN_ADD: begin
          acc_r   <= acc_nxt;
          ovf_r   <= ovf_r | sum_ovf;
          state_r <= use_quad ? S_SQ : S_END;
        end
        S_SQ: begin
          term_r  <= mul_res;
          ovf_r   <= ovf_r | mul_ovf;
          state_r <= S_QUAD;
        end
        S_QUAD: begin
          state_r <= S_QUAD_W;
        end
        S_QUAD_W: begin
          term_r  <= mul_res;
          ovf_r   <= ovf_r | mul_ovf;
          state_r <= S_QUAD_ADD;
        end
        S_QUAD_ADD: begin
          acc_r   <= acc_nxt;
          ovf_r   <= ovf_r | sum_ovf;
          state_r <= S_END;
        end
        S_END: begin
          if (!side_r) begin
            num_r   <= acc_r;
            side_r  <= 1'b1;
            state_r <= S_SIDE;
          end else if (acc_r == '0) begin
            // Zero denominator: saturate toward the numerator's sign
            dz_r    <= 1'b1;
            q_r     <= num_r[WORD-1] ? S_MIN : S_MAX;
            state_r <= S_DONE;
          end else begin
            dz_r    <= 1'b0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            q_r     <= div_res.quo;
            ovf_r   <= ovf_r | div_res.ovf;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r <= q_r;
            out_user_r <= {dz_r, ovf_r};
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
